// File: sv/plist_pkg.sv
// Package for the positional list engine: sizes, command, status and cell-op codes,
// and the controller-to-datapath struct.
// Depends on nothing; every other file imports it.
package plist_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMD_W  = 2;
  localparam int POS_W  = 5;
  localparam int DATA_W = 8;
  localparam int STAT_W = 2;

  localparam int IN_BITS   = CMD_W + POS_W + DATA_W;
  localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = STAT_W + DATA_W + CNT_W;
  localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_READ   = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LEFT  = 2'd2,
    CELL_FROM_RIGHT = 2'd3
  } cell_op_t;

  typedef struct packed {
    status_t          status;
    logic             rd_en;
    logic [CNT_W-1:0] count_next;
  } ctrl_t;

endpackage

// File: sv/plist_cell.sv
// One storage cell of the list row: holds a byte and takes it from data_in or a neighbor.
// Depends on plist_pkg.
module plist_cell
  import plist_pkg::*;
(
  input  logic              clk,
  input  cell_op_t          op,
  input  logic [DATA_W-1:0] din,
  input  logic [DATA_W-1:0] left,
  input  logic [DATA_W-1:0] right,
  output logic [DATA_W-1:0] q
);

  always_ff @(posedge clk) begin
    case (op)
      CELL_LOAD:       q <= din;
      CELL_FROM_LEFT:  q <= left;
      CELL_FROM_RIGHT: q <= right;
      default:         q <= q;
    endcase
  end

endmodule

// File: sv/plist_ctrl.sv
// Command decoder for the positional list engine: range checks, status, new count
// and the per-cell operation for every cell of the row. Depends on plist_pkg.
module plist_ctrl
  import plist_pkg::*;
(
  input  logic             accept,
  input  cmd_t             cmd,
  input  logic [POS_W-1:0] position,
  input  logic [CNT_W-1:0] count,
  output ctrl_t            ctrl,
  output cell_op_t         ops [DEPTH]
);

  logic full;
  logic pos_ins_bad;
  logic pos_acc_bad;

  assign full        = (count == CNT_W'(DEPTH));
  assign pos_ins_bad = (position > count);
  assign pos_acc_bad = (position >= count);

  always_comb begin
    ctrl.status     = ST_OK;
    ctrl.rd_en      = 1'b0;
    ctrl.count_next = count;
    unique case (cmd)
      CMD_APPEND: begin
        if (full) ctrl.status = ST_FULL;
        else      ctrl.count_next = count + 1'b1;
      end
      CMD_INSERT: begin
        if (pos_ins_bad) ctrl.status = ST_BADPOS;
        else if (full)   ctrl.status = ST_FULL;
        else             ctrl.count_next = count + 1'b1;
      end
      CMD_READ: begin
        if (pos_acc_bad) ctrl.status = ST_BADPOS;
        else             ctrl.rd_en = 1'b1;
      end
      CMD_DELETE: begin
        if (pos_acc_bad) ctrl.status = ST_BADPOS;
        else             ctrl.count_next = count - 1'b1;
      end
      default: ctrl.status = ST_OK;
    endcase
  end

  // Cells past the live count may take anything: their contents carry no meaning.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ops[i] = CELL_HOLD;
      if (accept && ctrl.status == ST_OK) begin
        case (cmd)
          CMD_APPEND: if (CNT_W'(i) == count) ops[i] = CELL_LOAD;
          CMD_INSERT: begin
            if (CNT_W'(i) == position)     ops[i] = CELL_LOAD;
            else if (CNT_W'(i) > position) ops[i] = CELL_FROM_LEFT;
          end
          CMD_DELETE: if (CNT_W'(i) >= position) ops[i] = CELL_FROM_RIGHT;
          default:    ops[i] = CELL_HOLD;
        endcase
      end
    end
  end

endmodule

// File: sv/positional_list_engine_top.sv
// Top level of the positional list engine: cell row, command decoder, result register.
// Depends on plist_pkg, plist_cell and plist_ctrl.
//
// Bounded ordered list of up to DEPTH (16) bytes held in a row of cells. Every command
// (append, insert at position, read at position, delete at position) is accepted by
// one handshake and yields exactly one result transaction with status (ok, bad position,
// full), read data (zero unless a successful read) and the entry count after the command.
// Insert and delete move all later entries by one place at once, each cell taking its
// neighbor's byte in the accept cycle, so the block sustains one command per clock; the
// result sits in an output register and s_axis_tready stays high while that register
// is empty or is being drained, so only m_axis_tready back-pressure slows it. The
// result register raises m_axis_tvalid in the cycle after accept. Reset clears only
// the count and the result valid flag; the cells need no clearing pass because no
// command ever reads a cell at or beyond the count.
module positional_list_engine_top
  import plist_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // {pad, data_in[14:7], position[6:2], cmd[1:0]}
  input  logic [IN_TDATA-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // {pad, entry_count[14:10], read_data[9:2], status[1:0]}
  output logic [OUT_TDATA-1:0] m_axis_tdata
);

  cmd_t              cmd;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] data_in;
  logic              accept;

  logic [CNT_W-1:0]  count;
  ctrl_t             ctrl;
  cell_op_t          ops [DEPTH];
  logic [DATA_W-1:0] q [DEPTH];

  status_t           out_status;
  logic [DATA_W-1:0] out_rdata;
  logic [CNT_W-1:0]  out_count;
  logic              out_valid;
  logic [DATA_W-1:0] rdata_next;

  // Unpack the command transaction.
  assign cmd      = cmd_t'(s_axis_tdata[CMD_W-1:0]);
  assign position = s_axis_tdata[CMD_W +: POS_W];
  assign data_in  = s_axis_tdata[CMD_W+POS_W +: DATA_W];

  // Take a new command whenever the result register is free or drains this cycle.
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  plist_ctrl u_ctrl (
    .accept   (accept),
    .cmd      (cmd),
    .position (position),
    .count    (count),
    .ctrl     (ctrl),
    .ops      (ops)
  );

  // Row of cells; the first cell's left input is never selected and the last cell's right
  // input only feeds a cell past the new count, so tie them to harmless values.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_nb;
    logic [DATA_W-1:0] right_nb;
    if (i == 0) begin : g_first
      assign left_nb = data_in;
    end else begin : g_left
      assign left_nb = q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_nb = q[i];
    end else begin : g_right
      assign right_nb = q[i+1];
    end
    plist_cell u_cell (
      .clk   (clk),
      .op    (ops[i]),
      .din   (data_in),
      .left  (left_nb),
      .right (right_nb),
      .q     (q[i])
    );
  end

  // Read tap: position is below count here, so the low bits address a live cell.
  assign rdata_next = ctrl.rd_en ? q[position[IDX_W-1:0]] : '0;

  // Hold the count and the result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= ctrl.count_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the result payload on accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= ctrl.status;
      out_rdata  <= rdata_next;
      out_count  <= ctrl.count_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA-OUT_BITS){1'b0}}, out_count, out_rdata, out_status};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above list depth");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_axis_tvalid && (out_count == count))
    else $error("result missing or count mismatch after accepted command");

  a_full_append: assert property (@(posedge clk) disable iff (rst)
    accept && cmd == CMD_APPEND && count == CNT_W'(DEPTH) |=> out_status == ST_FULL)
    else $error("append to full list not reported as full");

  a_rdata_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_status != ST_OK |-> out_rdata == '0)
    else $error("nonzero read data on failed command");
`endif

endmodule

// File: verif/tb_positional_list_engine_top.sv
`timescale 1ns / 1ps
// Testbench for positional_list_engine_top: queued list commands against a shadow list.
// Depends on plist_pkg and the engine RTL.
module tb_positional_list_engine_top;
  import plist_pkg::*;

  typedef struct packed {
    cmd_t              op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } list_cmd_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]  entry_count;
  } list_reply_t;

  localparam int RANDOM_ITEMS = 1700;
  localparam int PHASE_LEN    = 200;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // {pad, data_in[14:7], position[6:2], cmd[1:0]}
  logic [IN_TDATA-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // {pad, entry_count[14:10], read_data[9:2], status[1:0]}
  logic [OUT_TDATA-1:0] m_axis_tdata;

  positional_list_engine_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the list, updated once per accepted command.
  logic [DATA_W-1:0] list_bytes [0:DEPTH-1];
  int                list_count = 0;

  list_cmd_t   commands_waiting [$];
  list_reply_t replies_due [$];

  int total_items    = 0;
  int accepted_items = 0;
  int replies_seen   = 0;
  int mismatches     = 0;
  int peak_count     = 0;
  int cmd_hits    [4];
  int status_hits [3];

  // Entry count the queued commands will leave; steers the random mix between filling and draining.
  int plan_count = 0;

  // Apply one command to the shadow list and return the reply it must produce.
  function automatic list_reply_t apply_list_command(input list_cmd_t c);
    list_reply_t r;
    int p;
    int i;
    r.status    = ST_OK;
    r.read_data = '0;
    p = int'(c.pos);
    case (c.op)
      CMD_APPEND: begin
        if (list_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_bytes[list_count] = c.value;
          list_count++;
        end
      end
      CMD_INSERT: begin
        // Position check wins over the full check.
        if (p > list_count) begin
          r.status = ST_BADPOS;
        end else if (list_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_count; i > p; i--) list_bytes[i] = list_bytes[i-1];
          list_bytes[p] = c.value;
          list_count++;
        end
      end
      CMD_READ: begin
        if (p >= list_count) r.status = ST_BADPOS;
        else r.read_data = list_bytes[p];
      end
      default: begin
        if (p >= list_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = p; i + 1 < list_count; i++) list_bytes[i] = list_bytes[i+1];
          list_count--;
        end
      end
    endcase
    r.entry_count = CNT_W'(list_count);
    return r;
  endfunction

  // Idle phases rotate with progress: none, sender gaps, receiver stalls, both.
  function automatic int sender_idle_pct();
    case ((accepted_items / PHASE_LEN) % 4)
      1: return 46;
      3: return 28;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case ((accepted_items / PHASE_LEN) % 4)
      2: return 46;
      3: return 28;
      default: return 0;
    endcase
  endfunction

  // Queue a command and update the planned entry count.
  task automatic queue_command(input cmd_t op, input int pos, input int value);
    list_cmd_t c;
    c.op    = op;
    c.pos   = POS_W'(pos);
    c.value = DATA_W'(value);
    commands_waiting.push_back(c);
    total_items++;
    case (op)
      CMD_APPEND: if (plan_count < DEPTH) plan_count++;
      CMD_INSERT: if (pos <= plan_count && plan_count < DEPTH) plan_count++;
      CMD_DELETE: if (pos < plan_count) plan_count--;
      default: ;
    endcase
  endtask

  // Driver: record the accepted transaction, then present the next queued command
  // unless this cycle is an idle one.
  always @(posedge clk) begin : drive_commands
    list_cmd_t   sent;
    list_reply_t reply;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        sent.op    = cmd_t'(s_axis_tdata[1:0]);
        sent.pos   = s_axis_tdata[6:2];
        sent.value = s_axis_tdata[14:7];
        reply = apply_list_command(sent);
        replies_due.push_back(reply);
        accepted_items++;
        cmd_hits[sent.op]++;
        status_hits[reply.status]++;
        if (list_count > peak_count) peak_count = list_count;
      end
      // Hold the current command while it waits for tready.
      if (!s_axis_tvalid || s_axis_tready) begin
        if (commands_waiting.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
          sent = commands_waiting.pop_front();
          s_axis_tdata  <= IN_TDATA'({sent.value, sent.pos, sent.op});
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each reply transaction with the oldest expectation, then pick
  // tready for the next cycle.
  always @(posedge clk) begin : check_replies
    list_reply_t got;
    list_reply_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status      = status_t'(m_axis_tdata[1:0]);
        got.read_data   = m_axis_tdata[9:2];
        got.entry_count = m_axis_tdata[14:10];
        replies_seen++;
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: reply with nothing expected: status %0d data %02h count %0d",
                     $realtime, got.status, got.read_data, got.entry_count);
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status || got.read_data !== want.read_data ||
              got.entry_count !== want.entry_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: reply %0d mismatch: expected status %0d data %02h count %0d,",
                       $realtime, replies_seen, want.status, want.read_data,
                       want.entry_count);
              $display("    got status %0d data %02h count %0d",
                       got.status, got.read_data, got.entry_count);
            end
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct());
    end
  end

  initial begin : run_test
    int  n;
    int  roll;
    int  pos;
    bit  filling;
    cmd_t op;

    // Directed: empty-list failures, inserts at both ends, fill to full, full-list
    // failures, and reads and deletes at the boundary positions.
    queue_command(CMD_READ,   0,  8'h11);
    queue_command(CMD_DELETE, 0,  8'h22);
    queue_command(CMD_INSERT, 1,  8'hAA);
    queue_command(CMD_INSERT, 0,  8'h00);
    queue_command(CMD_APPEND, 16, 8'hFF);
    queue_command(CMD_INSERT, 2,  8'h5A);
    queue_command(CMD_INSERT, 0,  8'hA5);
    queue_command(CMD_READ,   0,  8'h00);
    queue_command(CMD_READ,   3,  8'h00);
    queue_command(CMD_READ,   4,  8'hFF);
    while (plan_count < DEPTH)
      queue_command(CMD_APPEND, 0, (plan_count % 2) ? 8'h7F : 8'h80);
    queue_command(CMD_APPEND, 0,  8'h3C);
    queue_command(CMD_INSERT, 16, 8'hC3);
    queue_command(CMD_READ,   15, 8'h00);
    queue_command(CMD_READ,   16, 8'h00);
    queue_command(CMD_DELETE, 15, 8'h00);
    queue_command(CMD_DELETE, 0,  8'hFF);
    queue_command(CMD_INSERT, 16, 8'h55);

    // Random: swing between filling and draining so the list keeps reaching both
    // full and empty; most positions are in range, the rest anywhere in 0..16.
    filling = 1'b1;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (plan_count == DEPTH) filling = 1'b0;
      else if (plan_count == 0) filling = 1'b1;
      else if ($urandom_range(0, 99) < 2) filling = !filling;
      roll = $urandom_range(0, 99);
      if (filling)
        op = (roll < 40) ? CMD_APPEND : (roll < 75) ? CMD_INSERT :
             (roll < 90) ? CMD_READ : CMD_DELETE;
      else
        op = (roll < 15) ? CMD_APPEND : (roll < 30) ? CMD_INSERT :
             (roll < 55) ? CMD_READ : CMD_DELETE;
      if ($urandom_range(0, 99) < 12 || op == CMD_APPEND)
        pos = $urandom_range(0, 16);
      else if (op == CMD_INSERT)
        pos = $urandom_range(0, plan_count);
      else
        pos = (plan_count == 0) ? 0 : $urandom_range(0, plan_count - 1);
      queue_command(op, pos, $urandom_range(0, 255));
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Drain: every command accepted, every reply back, then a few quiet cycles to
    // catch any stray reply.
    while (accepted_items < total_items) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d commands (append %0d, insert %0d, read %0d, delete %0d), %0d replies.",
             accepted_items, cmd_hits[CMD_APPEND], cmd_hits[CMD_INSERT],
             cmd_hits[CMD_READ], cmd_hits[CMD_DELETE], replies_seen);
    $display("Statuses ok %0d, bad position %0d, full %0d; peak fill %0d; mismatches %0d.",
             status_hits[ST_OK], status_hits[ST_BADPOS], status_hits[ST_FULL],
             peak_count, mismatches);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("Timeout: %0d of %0d commands accepted, %0d replies outstanding.",
             accepted_items, total_items, replies_due.size());
    $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
sv/plist_pkg.sv
sv/plist_cell.sv
sv/plist_ctrl.sv
sv/positional_list_engine_top.sv
verif/tb_positional_list_engine_top.sv
